### hdl/fatx_pkg.sv
// ----------------------------------------------------------------------------
// fatx_pkg: shared definitions of the framed transmitter
// Widths, phase codes, operation codes, register indexes and frame bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fatx_pkg;

    localparam int unsigned MAX_PAYLOAD = 256;
    localparam int unsigned ADDR_W      = $clog2(MAX_PAYLOAD);
    localparam int unsigned LEN_W       = 9;
    localparam int unsigned TMR_W       = 16;
    localparam int unsigned POS_W       = 3;
    localparam int unsigned OP_W        = 2;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 16;

    // Message phases.
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_START = 2'd1;
    localparam logic [1:0] PH_DATA  = 2'd2;
    localparam logic [1:0] PH_STOP  = 2'd3;

    // Request operations.
    localparam logic [OP_W-1:0] OP_START = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
    localparam logic [OP_W-1:0] OP_LINK  = 2'd2;
    localparam logic [OP_W-1:0] OP_TICK  = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BRIDGE_ID = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_ID    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 2'd2;

    localparam logic [TMR_W-1:0] TIMEOUT_RESET = 16'd1000;

    // Frame bytes.
    localparam logic [7:0] CMD_MARK  = 8'd251;
    localparam logic [7:0] DATA_MARK = 8'd252;
    localparam logic [7:0] ACK_BYTE  = 8'd254;
    localparam logic [7:0] CMD_START = 8'd1;
    localparam logic [7:0] CMD_STOP  = 8'd2;

    // Position of the checksum byte in each frame type.
    localparam logic [POS_W-1:0] CMD_LAST  = 3'd7;
    localparam logic [POS_W-1:0] DATA_LAST = 3'd4;

    function automatic logic [POS_W-1:0] frame_last(input logic [1:0] phase);
        return (phase == PH_DATA) ? DATA_LAST : CMD_LAST;
    endfunction

endpackage

`default_nettype wire

### hdl/fatx_req_if.sv
// ----------------------------------------------------------------------------
// fatx_req_if: request channel of the framed transmitter
// Valid/ready handshake with the request fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface fatx_req_if import fatx_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [OP_W-1:0]       op;
    logic [7:0]            dest_id;
    logic [LEN_W-1:0]      msg_length;
    logic [ADDR_W-1:0]     load_index;
    logic [7:0]            load_byte;
    logic [7:0]            link_byte;

    modport source (output valid, op, dest_id, msg_length, load_index, load_byte,
                    link_byte, input ready);
    modport sink (input valid, op, dest_id, msg_length, load_index, load_byte,
                  link_byte, output ready);
endinterface

`default_nettype wire

### hdl/fatx_res_if.sv
// ----------------------------------------------------------------------------
// fatx_res_if: result channel of the framed transmitter
// Valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface fatx_res_if ();
    logic       valid;
    logic       ready;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       msg_done;
    logic       busy_res;

    modport source (output valid, tx_valid, tx_byte, msg_done, busy_res, input ready);
    modport sink (input valid, tx_valid, tx_byte, msg_done, busy_res, output ready);
endinterface

`default_nettype wire

### hdl/fatx_ram.sv
// ----------------------------------------------------------------------------
// fatx_ram: payload store
// One write port, one registered read port; a write to the address being
// read in the same cycle is forwarded to the read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fatx_ram #(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned WIDTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### hdl/framed_ack_per_byte_transmitter.sv
// ----------------------------------------------------------------------------
// framed_ack_per_byte_transmitter: stop-and-wait framed byte transmitter
// Path: input register, single state update stage, result register.
// Throughput: one request per cycle unless a result waits to be taken.
// Reset: synchronous, active low; state returns to idle, timeout 1000.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// Overview
//
// A message is a start command frame, one data frame per payload byte and a
// stop command frame. Each transmitted byte waits for an acknowledge byte
// from the link before the next one goes out. A tick that runs the wait timer
// up to the timeout restarts the current frame from its first byte with a
// cleared checksum. The closing byte of each frame is the 8-bit wrapping sum
// of the bytes sent before it in that frame.
//
// Pipeline
//
// Requests land in an input register. From there, the logic updates
// the transmitter state and writes the result register. The input register
// takes a new request whenever it is empty or its request moves on in the
// same cycle, so the input side stalls only once a request is already held
// behind a result that is waiting to be taken.
//
// The payload store is read every cycle at the next value of the data frame
// counter, so the byte for the current data frame is already registered when
// the payload position of that frame is reached.

module framed_ack_per_byte_transmitter
    import fatx_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    fatx_req_if.sink                   i_req,
    fatx_res_if.source                 o_res
);

    // Configuration registers.
    logic [7:0]       r_bridge_id;
    logic [7:0]       r_own_id;
    logic [TMR_W-1:0] r_timeout;

    // Input register.
    logic              r_in_valid;
    logic [OP_W-1:0]   r_op;
    logic [7:0]        r_dest_id;
    logic [LEN_W-1:0]  r_msg_length;
    logic [ADDR_W-1:0] r_load_index;
    logic [7:0]        r_load_byte;
    logic [7:0]        r_link_byte;

    // Transmitter state.
    logic [1:0]       r_phase,       n_phase;
    logic [POS_W-1:0] r_pos,         n_pos;
    logic [7:0]       r_sum,         n_sum;
    logic [LEN_W-1:0] r_frames,      n_frames;
    logic [TMR_W-1:0] r_timer,       n_timer;
    logic             r_waiting,     n_waiting;
    logic [7:0]       r_target_id,   n_target_id;
    logic [LEN_W-1:0] r_target_len,  n_target_len;

    // Result register.
    logic       r_out_valid;
    logic       r_tx_valid,  n_tx_valid;
    logic [7:0] r_tx_byte,   n_tx_byte;
    logic       r_msg_done,  n_msg_done;
    logic       r_busy;

    logic             w_fire;
    logic             w_accept;
    logic             w_ram_we;
    logic [7:0]       w_payload;
    logic [7:0]       w_sum_base;
    logic [TMR_W:0]   w_tick_count;
    logic [LEN_W-1:0] w_next_frames;
    logic [LEN_W-1:0] w_len_sat;

    // The item in the input register moves on when the result register is
    // free or is being emptied in this cycle.
    assign w_fire   = r_in_valid && (!r_out_valid || o_res.ready);
    assign w_accept = i_req.valid && i_req.ready;
    assign i_req.ready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bridge_id <= '0;
            r_own_id    <= '0;
            r_timeout   <= TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BRIDGE_ID: r_bridge_id <= i_cfg_data[7:0];
                REG_OWN_ID:    r_own_id    <= i_cfg_data[7:0];
                REG_TIMEOUT:   r_timeout   <= i_cfg_data[TMR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op         <= i_req.op;
            r_dest_id    <= i_req.dest_id;
            r_msg_length <= i_req.msg_length;
            r_load_index <= i_req.load_index;
            r_load_byte  <= i_req.load_byte;
            r_link_byte  <= i_req.link_byte;
        end
    end

    // Loads are taken only while no message is in progress.
    assign w_ram_we = w_fire && (r_op == OP_LOAD) && (r_phase == PH_IDLE);

    fatx_ram #(
        .DEPTH (MAX_PAYLOAD),
        .WIDTH (8)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_load_index),
        .i_wdata (r_load_byte),
        .i_raddr (n_frames[ADDR_W-1:0]),
        .o_rdata (w_payload)
    );

    assign w_len_sat    = (r_msg_length > LEN_W'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD)
                                                              : r_msg_length;
    assign w_tick_count = {1'b0, r_timer} + (TMR_W+1)'(1);
    assign w_next_frames = (r_phase == PH_DATA) ? (r_frames + LEN_W'(1)) : '0;

    always_comb begin
        n_phase      = r_phase;
        n_pos        = r_pos;
        n_sum        = r_sum;
        n_frames     = r_frames;
        n_timer      = r_timer;
        n_waiting    = r_waiting;
        n_target_id  = r_target_id;
        n_target_len = r_target_len;
        n_tx_valid   = 1'b0;
        n_tx_byte    = '0;
        n_msg_done   = 1'b0;
        w_sum_base   = r_sum;

        if (w_fire) begin
            case (r_op)
                OP_START: begin
                    if (r_phase == PH_IDLE) begin
                        n_target_id  = r_dest_id;
                        n_target_len = w_len_sat;
                        n_frames     = '0;
                        n_phase      = PH_START;
                        n_pos        = '0;
                        w_sum_base   = '0;
                        n_tx_valid   = 1'b1;
                    end
                end
                OP_LINK: begin
                    if ((r_phase != PH_IDLE) && r_waiting && (r_link_byte == ACK_BYTE)) begin
                        if (r_pos != frame_last(r_phase)) begin
                            n_pos      = r_pos + POS_W'(1);
                            n_tx_valid = 1'b1;
                        end else if (r_phase == PH_STOP) begin
                            // Stop frame checksum acknowledged: message finished.
                            n_phase    = PH_IDLE;
                            n_pos      = '0;
                            n_sum      = '0;
                            n_waiting  = 1'b0;
                            n_timer    = '0;
                            n_msg_done = 1'b1;
                        end else begin
                            n_frames   = w_next_frames;
                            n_phase    = (w_next_frames >= r_target_len) ? PH_STOP : PH_DATA;
                            n_pos      = '0;
                            w_sum_base = '0;
                            n_tx_valid = 1'b1;
                        end
                    end
                end
                OP_TICK: begin
                    if ((r_phase != PH_IDLE) && r_waiting) begin
                        n_timer = w_tick_count[TMR_W-1:0];
                        if (w_tick_count >= {1'b0, r_timeout}) begin
                            n_pos      = '0;
                            w_sum_base = '0;
                            n_tx_valid = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase

            if (n_tx_valid) begin
                if (n_pos == '0) begin
                    n_tx_byte = r_bridge_id;
                end else if (n_phase == PH_DATA) begin
                    case (n_pos)
                        3'd1:    n_tx_byte = DATA_MARK;
                        3'd2:    n_tx_byte = r_target_id;
                        3'd3:    n_tx_byte = w_payload;
                        default: n_tx_byte = w_sum_base;
                    endcase
                end else begin
                    case (n_pos)
                        3'd1:    n_tx_byte = CMD_MARK;
                        3'd2:    n_tx_byte = r_own_id;
                        3'd3:    n_tx_byte = n_target_id;
                        3'd4:    n_tx_byte = n_target_len[7:0];
                        3'd5:    n_tx_byte = 8'(n_target_len[LEN_W-1:8]);
                        3'd6:    n_tx_byte = (n_phase == PH_STOP) ? CMD_STOP : CMD_START;
                        default: n_tx_byte = w_sum_base;
                    endcase
                end
                n_sum     = (n_pos != frame_last(n_phase)) ? (w_sum_base + n_tx_byte)
                                                           : w_sum_base;
                n_timer   = '0;
                n_waiting = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_pos        <= '0;
            r_sum        <= '0;
            r_frames     <= '0;
            r_timer      <= '0;
            r_waiting    <= 1'b0;
            r_target_id  <= '0;
            r_target_len <= '0;
        end else begin
            r_phase      <= n_phase;
            r_pos        <= n_pos;
            r_sum        <= n_sum;
            r_frames     <= n_frames;
            r_timer      <= n_timer;
            r_waiting    <= n_waiting;
            r_target_id  <= n_target_id;
            r_target_len <= n_target_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_tx_valid <= n_tx_valid;
            r_tx_byte  <= n_tx_byte;
            r_msg_done <= n_msg_done;
            r_busy     <= (n_phase != PH_IDLE);
        end
    end

    assign o_res.valid    = r_out_valid;
    assign o_res.tx_valid = r_tx_valid;
    assign o_res.tx_byte  = r_tx_byte;
    assign o_res.msg_done = r_msg_done;
    assign o_res.busy_res = r_busy;

`ifndef SYNTHESIS
    // An acknowledge is awaited only inside a message.
    a_wait_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_waiting |-> (r_phase != PH_IDLE))
        else $error("waiting for acknowledge while idle");

    // The frame position never passes the checksum byte of its frame.
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= frame_last(r_phase))
        else $error("frame position beyond checksum byte");

    // Data frames are sent only for payload bytes that exist.
    a_data_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_frames < r_target_len))
        else $error("data frame counter beyond message length");

    // A finished message leaves the block idle in the same result.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_msg_done) |-> (!r_busy && !r_tx_valid))
        else $error("message done while still busy or sending");

    // A finished stop frame returns the state to idle.
    a_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && n_msg_done) |=> ((r_phase == PH_IDLE) && !r_waiting))
        else $error("state not idle after message done");
`endif

endmodule

`default_nettype wire
